// ===== hw/rtl/compacting_device_table_macros.svh =====
// Assertion macros shared by the device table RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef COMPACTING_DEVICE_TABLE_MACROS_SVH
`define COMPACTING_DEVICE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("device table check failed");

// Consequent must hold in the cycle after the antecedent.
`define CDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("device table check failed");

`endif

// ===== hw/rtl/cdt_pkg.sv =====
// Package for the compacting device table: sizes, codes, payload and command types.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cdt_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int ID_BYTES    = 4;
	localparam int USER_BYTES  = 8;

	// Fixed field widths of the transfers.
	localparam int OP_W    = 3;
	localparam int ID_W    = 32;
	localparam int IDX_W   = 4;
	localparam int COL_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int OUT_W   = 2;
	localparam int FOUND_W = 4;
	localparam int TOTAL_W = 5;

	// Derived internal widths.
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ROW_W = USER_BYTES * BYTE_W;

	// Only the low ID_BYTES bytes of an ID take part.
	localparam logic [ID_W-1:0] ID_MASK = (ID_BYTES >= 4) ? {ID_W{1'b1}} :
		ID_W'((64'd1 << (8 * ID_BYTES)) - 64'd1);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
	localparam logic [OP_W-1:0] OP_COUNT  = 3'd6;

	// Outcome codes.
	localparam logic [OUT_W-1:0] RES_OK        = 2'd0;
	localparam logic [OUT_W-1:0] RES_FULL      = 2'd1;
	localparam logic [OUT_W-1:0] RES_NOT_FOUND = 2'd2;
	localparam logic [OUT_W-1:0] RES_RANGE     = 2'd3;

	// Pointer updates.
	localparam logic [2:0] PTR_HOLD = 3'd0;
	localparam logic [2:0] PTR_ZERO = 3'd1;
	localparam logic [2:0] PTR_IDX  = 3'd2;
	localparam logic [2:0] PTR_IDX1 = 3'd3;
	localparam logic [2:0] PTR_INC  = 3'd4;

	// Write address selection.
	localparam logic [1:0] WA_COUNT = 2'd0;
	localparam logic [1:0] WA_PTR   = 2'd1;
	localparam logic [1:0] WA_PREV  = 2'd2;

	// User row write data selection.
	localparam logic [1:0] USR_ZERO  = 2'd0;
	localparam logic [1:0] USR_COPY  = 2'd1;
	localparam logic [1:0] USR_MERGE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [ID_W-1:0]   device_ident;
		logic [IDX_W-1:0]  entry_index;
		logic [COL_W-1:0]  byte_column;
		logic [BYTE_W-1:0] write_value;
	} req_item_t;

	typedef struct packed {
		logic [OUT_W-1:0]   outcome;
		logic [FOUND_W-1:0] found_index;
		logic [BYTE_W-1:0]  read_byte;
		logic [TOTAL_W-1:0] entry_total;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             take;
		logic [2:0]       ptr_op;
		logic [1:0]       wa_sel;
		logic             id_we;
		logic             usr_we;
		logic [1:0]       usr_src;
		logic             id_src_rd;
		logic             cnt_inc;
		logic             cnt_dec;
		logic             set_out;
		logic [OUT_W-1:0] out_code;
		logic             found_ld;
		logic             found_ptr;
		logic             rbyte_ld;
		logic             emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            idx_ok;
		logic            col_ok;
		logic            ptr_end;
		logic            ptr_last;
		logic            match;
		logic            out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/compacting_device_table.sv =====
// Compacting device table top level: controller plus datapath; uses cdt_pkg.
// Add, count and rejected requests finish in the decode state; read and write read the row first,
// a lookup compares one entry at a time, a remove moves each later entry down one place and a clear
// zeroes the user rows of the live entries; the walk runs one entry at a time.
// A new request is taken the cycle after its predecessor's result is loaded into the output.
// Reset empties the table (count zero) with no clearing pass; memory contents stay undefined.
`default_nettype none

module compacting_device_table (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  cdt_pkg::req_item_t  req_item,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output cdt_pkg::rsp_item_t  rsp_item
);
	import cdt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	cdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	cdt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/cdt_datapath.sv =====
// Datapath of the device table: request latch, ID and user-data memories, count,
// walk pointer and result/output registers. Depends on cdt_pkg and the macros header.
`default_nettype none

`include "compacting_device_table_macros.svh"

module cdt_datapath (
	input  wire               clk,
	input  wire               arst_n,
	input  cdt_pkg::req_item_t req_item,
	input  cdt_pkg::dp_cmd_t  cmd,
	output cdt_pkg::dp_status_t st,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output cdt_pkg::rsp_item_t rsp_item
);
	import cdt_pkg::*;

	req_item_t          req_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   ptr_prev;
	logic [AW-1:0]      wa;
	logic [AW-1:0]      ra;
	logic [ID_W-1:0]    ident_mem [MAX_ENTRIES];
	logic [ROW_W-1:0]   user_mem [MAX_ENTRIES];
	logic [ID_W-1:0]    rd_id_q;
	logic [ROW_W-1:0]   rd_usr_q;
	logic [ID_W-1:0]    id_wdata;
	logic [ROW_W-1:0]   usr_wdata;
	logic [ROW_W-1:0]   merged;
	logic [BYTE_W-1:0]  sel_byte;
	logic [OUT_W-1:0]   outcome_q;
	logic [FOUND_W-1:0] found_q;
	logic [BYTE_W-1:0]  rbyte_q;
	rsp_item_t          out_q;
	logic               out_valid_q;
	logic               out_free;

	// Latch the request; the ID is masked once here so lookups compare directly.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= '{opcode: req_item.opcode,
				device_ident: req_item.device_ident & ID_MASK,
				entry_index: req_item.entry_index,
				byte_column: req_item.byte_column,
				write_value: req_item.write_value};
		end
	end

	// Entry count and walk pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			case (cmd.ptr_op)
				PTR_ZERO: ptr_q <= '0;
				PTR_IDX:  ptr_q <= CNT_W'(req_q.entry_index);
				PTR_IDX1: ptr_q <= CNT_W'(req_q.entry_index) + CNT_W'(1);
				PTR_INC:  ptr_q <= ptr_q + CNT_W'(1);
				default:  ptr_q <= ptr_q;
			endcase
		end
	end

	assign ptr_prev = ptr_q - CNT_W'(1);
	assign ra       = ptr_q[AW-1:0];

	// Write address for the memories.
	always_comb begin
		case (cmd.wa_sel)
			WA_COUNT: wa = count_q[AW-1:0];
			WA_PTR:   wa = ptr_q[AW-1:0];
			WA_PREV:  wa = ptr_prev[AW-1:0];
			default:  wa = ptr_q[AW-1:0];
		endcase
	end

	// Byte selection and byte merge within the row read last.
	always_comb begin
		merged   = rd_usr_q;
		sel_byte = '0;
		for (int b = 0; b < USER_BYTES; b++) begin
			if (32'(req_q.byte_column) == b) begin
				merged[b*BYTE_W +: BYTE_W] = req_q.write_value;
				sel_byte                   = rd_usr_q[b*BYTE_W +: BYTE_W];
			end
		end
	end

	// Write data for the memories.
	always_comb begin
		id_wdata = cmd.id_src_rd ? rd_id_q : req_q.device_ident;
		case (cmd.usr_src)
			USR_ZERO:  usr_wdata = '0;
			USR_COPY:  usr_wdata = rd_usr_q;
			USR_MERGE: usr_wdata = merged;
			default:   usr_wdata = '0;
		endcase
	end

	// ID and user-data memories, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.id_we) begin
			ident_mem[wa] <= id_wdata;
		end
		if (cmd.usr_we) begin
			user_mem[wa] <= usr_wdata;
		end
		rd_id_q  <= ident_mem[ra];
		rd_usr_q <= user_mem[ra];
	end

	// Result fields, cleared at each new request.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			outcome_q <= RES_OK;
			found_q   <= '0;
			rbyte_q   <= '0;
		end else begin
			if (cmd.set_out) begin
				outcome_q <= cmd.out_code;
			end
			if (cmd.found_ld) begin
				found_q <= cmd.found_ptr ? FOUND_W'(ptr_q) : FOUND_W'(count_q);
			end
			if (cmd.rbyte_ld) begin
				rbyte_q <= sel_byte;
			end
		end
	end

	// Output register; it holds a finished result while the next request runs.
	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= '{outcome: outcome_q,
				found_index: found_q,
				read_byte: rbyte_q,
				entry_total: TOTAL_W'(count_q)};
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	// Status toward the controller.
	always_comb begin
		st.op       = req_q.opcode;
		st.full     = (count_q == CNT_W'(MAX_ENTRIES));
		st.empty    = (count_q == '0);
		st.idx_ok   = (32'(req_q.entry_index) < 32'(count_q));
		st.col_ok   = (32'(req_q.byte_column) < USER_BYTES);
		st.ptr_end  = (ptr_q >= count_q);
		st.ptr_last = ((ptr_q + CNT_W'(1)) >= count_q);
		st.match    = (rd_id_q == req_q.device_ident);
		st.out_free = out_free;
	end

	`CDT_ASSERT_IMPL(a_inc_room, cmd.cnt_inc, count_q < CNT_W'(MAX_ENTRIES))
	`CDT_ASSERT_IMPL(a_dec_live, cmd.cnt_dec, count_q != '0 && !cmd.cnt_inc)
	`CDT_ASSERT_IMPL(a_wr_live, cmd.usr_we && cmd.wa_sel == WA_PTR, ptr_q < count_q)
	`CDT_ASSERT_IMPL(a_emit_free, cmd.emit, !out_valid_q || !rsp_stall)

endmodule

`default_nettype wire

// ===== hw/rtl/cdt_ctrl.sv =====
// Controller state machine of the device table: sequences each operation over the datapath.
// Depends on cdt_pkg for the command, status and code definitions.
`default_nettype none

module cdt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  cdt_pkg::dp_status_t st,
	output cdt_pkg::dp_cmd_t    cmd
);
	import cdt_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LK_RD  = 4'd2;
	localparam logic [3:0] S_LK_CMP = 4'd3;
	localparam logic [3:0] S_RM_RD  = 4'd4;
	localparam logic [3:0] S_RM_WR  = 4'd5;
	localparam logic [3:0] S_RW_RD  = 4'd6;
	localparam logic [3:0] S_RW_DO  = 4'd7;
	localparam logic [3:0] S_CLR    = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				case (st.op)
					OP_ADD: begin
						if (st.full) begin
							cmd.set_out  = 1'b1;
							cmd.out_code = RES_FULL;
						end else begin
							cmd.wa_sel   = WA_COUNT;
							cmd.id_we    = 1'b1;
							cmd.usr_we   = 1'b1;
							cmd.usr_src  = USR_ZERO;
							cmd.found_ld = 1'b1;
							cmd.cnt_inc  = 1'b1;
						end
					end
					OP_LOOKUP: begin
						cmd.ptr_op = PTR_ZERO;
						if (st.empty) begin
							cmd.set_out  = 1'b1;
							cmd.out_code = RES_NOT_FOUND;
						end else begin
							state_d = S_LK_RD;
						end
					end
					OP_REMOVE: begin
						if (!st.idx_ok) begin
							cmd.set_out  = 1'b1;
							cmd.out_code = RES_RANGE;
						end else begin
							cmd.ptr_op = PTR_IDX1;
							state_d    = S_RM_RD;
						end
					end
					OP_READ, OP_WRITE: begin
						if (!st.idx_ok || !st.col_ok) begin
							cmd.set_out  = 1'b1;
							cmd.out_code = RES_RANGE;
						end else begin
							cmd.ptr_op = PTR_IDX;
							state_d    = S_RW_RD;
						end
					end
					OP_CLEAR: begin
						cmd.ptr_op = PTR_ZERO;
						state_d    = S_CLR;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			// The memory captures the ID at the pointer.
			S_LK_RD: begin
				state_d = S_LK_CMP;
			end
			S_LK_CMP: begin
				if (st.match) begin
					cmd.found_ld  = 1'b1;
					cmd.found_ptr = 1'b1;
					state_d       = S_FIN;
				end else if (st.ptr_last) begin
					cmd.set_out  = 1'b1;
					cmd.out_code = RES_NOT_FOUND;
					state_d      = S_FIN;
				end else begin
					cmd.ptr_op = PTR_INC;
					state_d    = S_LK_RD;
				end
			end
			// Pointer names the source entry; it moves down one place.
			S_RM_RD: begin
				if (st.ptr_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FIN;
				end else begin
					state_d = S_RM_WR;
				end
			end
			S_RM_WR: begin
				cmd.wa_sel    = WA_PREV;
				cmd.id_we     = 1'b1;
				cmd.id_src_rd = 1'b1;
				cmd.usr_we    = 1'b1;
				cmd.usr_src   = USR_COPY;
				cmd.ptr_op    = PTR_INC;
				state_d       = S_RM_RD;
			end
			S_RW_RD: begin
				state_d = S_RW_DO;
			end
			S_RW_DO: begin
				if (st.op == OP_READ) begin
					cmd.rbyte_ld = 1'b1;
				end else begin
					cmd.wa_sel  = WA_PTR;
					cmd.usr_we  = 1'b1;
					cmd.usr_src = USR_MERGE;
				end
				state_d = S_FIN;
			end
			// One user row zeroed per cycle.
			S_CLR: begin
				if (st.ptr_end) begin
					state_d = S_FIN;
				end else begin
					cmd.wa_sel  = WA_PTR;
					cmd.usr_we  = 1'b1;
					cmd.usr_src = USR_ZERO;
					cmd.ptr_op  = PTR_INC;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
